>>> rtl/core/bit_toggle_stream_scrambler_assert.svh
// Assertion macros shared by the scrambler RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BIT_TOGGLE_STREAM_SCRAMBLER_ASSERT_SVH
`define BIT_TOGGLE_STREAM_SCRAMBLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BTSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("btss assertion failed");
`define BTSS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define BTSS_ASSERT(lbl, prop)
`define BTSS_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> rtl/core/btss_pkg.sv
// Package for the bit toggle stream scrambler: field widths, command codes,
// reset constants and the controller/datapath command and status structs.
package btss_pkg;

  localparam int KEY_IDX_W = 6;
  localparam int BYTE_W    = 8;
  localparam int BIT_W     = 3;
  localparam int CHUNK_W   = 16;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd30000;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic in_ready;
    logic key_wr1;
    logic key_wr2;
    logic data_acc;
    logic out_load;
    logic x_start;
    logic x_rda;
    logic x_geta;
    logic x_rdb;
    logic x_calc;
  } btss_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic idx_ok;
    logic idx_last;
    logic out_free;
    logic x_end;
    logic pass_last;
  } btss_stat_t;

endpackage

>>> rtl/core/btss_if.sv
// Valid/ready channel interfaces for the scrambler: request input,
// result output and configuration write. Depends on btss_pkg.
interface btss_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [btss_pkg::KEY_IDX_W-1:0]  key_index;
  logic [btss_pkg::BYTE_W-1:0]     key_byte;
  logic [btss_pkg::BYTE_W-1:0]     data_byte;

  modport source (output valid, cmd, key_index, key_byte, data_byte, input ready);
  modport sink   (input valid, cmd, key_index, key_byte, data_byte, output ready);
endinterface

interface btss_out_if;
  logic                        valid;
  logic                        ready;
  logic [btss_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

interface btss_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [btss_pkg::CHUNK_W-1:0] chunk_length;

  modport source (output valid, chunk_length, input ready);
  modport sink   (input valid, chunk_length, output ready);
endinterface

>>> rtl/core/btss_datapath.sv
// Scrambler datapath: schedule memory, position and chunk counters,
// expansion arithmetic and output register. Depends on btss_pkg, btss_if.
`include "bit_toggle_stream_scrambler_assert.svh"

module btss_datapath #(
  parameter int KEY_LEN = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  btss_in_if.sink             in_if,
  btss_out_if.source          out_if,
  btss_cfg_if.sink            cfg_if,
  input  btss_pkg::btss_cmd_t cmd_i,
  output btss_pkg::btss_stat_t stat_o
);

  localparam int SCHED_LEN = 2 * KEY_LEN;
  localparam int PW        = $clog2(SCHED_LEN);
  localparam int CW        = btss_pkg::CHUNK_W;
  localparam int BW        = btss_pkg::BIT_W;

  logic [BW-1:0]                  mem [SCHED_LEN];
  logic [BW-1:0]                  rdata_r;
  logic                           rd_en;
  logic [PW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [PW-1:0]                  wr_addr;
  logic [BW-1:0]                  wr_data;

  logic [PW-1:0]                  pos_r, pos_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  chunk_len_r;
  logic [CW:0]                    limit;
  logic [CW:0]                    count_inc;

  logic [PW-1:0]                  kidx_r;
  logic [BW-1:0]                  key_r;
  logic [btss_pkg::BYTE_W-1:0]    data_r;
  logic [btss_pkg::BYTE_W-1:0]    out_byte_r;
  logic                           out_valid_r;

  logic [PW-1:0]                  i_r;
  logic                           pass_r;
  logic [BW-1:0]                  a_r;
  logic [BW-1:0]                  b;
  logic                           eq;
  logic [PW+1:0]                  b_plus_2i;
  logic [BW-1:0]                  new_a, new_b;
  logic [PW-1:0]                  i_inc;

  assign in_if.ready   = cmd_i.in_ready;
  assign cfg_if.ready  = rst_n;
  assign out_if.valid  = out_valid_r;
  assign out_if.out_byte = out_byte_r;

  assign stat_o.in_valid  = in_if.valid;
  assign stat_o.in_cmd    = in_if.cmd;
  assign stat_o.idx_ok    = 32'(in_if.key_index) < 32'(KEY_LEN);
  assign stat_o.idx_last  = kidx_r == PW'(KEY_LEN - 1);
  assign stat_o.out_free  = !out_valid_r || out_if.ready;
  assign stat_o.x_end     = i_r == PW'(SCHED_LEN - 2);
  assign stat_o.pass_last = pass_r;

  // expansion step
  assign b         = rdata_r;
  assign eq        = a_r == b;
  assign b_plus_2i = (PW+2)'(b) + (PW+2)'({i_r, 1'b0});
  assign new_a     = BW'(a_r + b + {i_r[1:0], 1'b0});
  assign new_b     = (b_plus_2i > (PW+2)'(7)) ? BW'(b + i_r[2:0] + {i_r[1:0], 1'b0})
                                              : b_plus_2i[BW-1:0];
  assign i_inc     = i_r + PW'(1);

  always_comb begin
    rd_en   = cmd_i.data_acc | cmd_i.x_rda | cmd_i.x_geta | cmd_i.x_rdb;
    rd_addr = i_inc;
    if (cmd_i.data_acc) begin
      rd_addr = pos_r;
    end else if (cmd_i.x_rda) begin
      rd_addr = i_r;
    end
    wr_en   = cmd_i.key_wr1 | cmd_i.key_wr2 | cmd_i.x_calc;
    wr_addr = PW'(in_if.key_index);
    wr_data = in_if.key_byte[BW-1:0];
    if (cmd_i.key_wr2) begin
      wr_addr = kidx_r + PW'(KEY_LEN);
      wr_data = key_r;
    end else if (cmd_i.x_calc) begin
      wr_addr = eq ? i_r : i_inc;
      wr_data = eq ? new_a : new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // chunk and position counters
  assign limit     = (chunk_len_r == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, chunk_len_r};
  assign count_inc = {1'b0, count_r} + (CW+1)'(1);

  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    if (cmd_i.key_wr1) begin
      pos_nxt   = '0;
      count_nxt = '0;
    end else if (cmd_i.data_acc) begin
      if (count_inc >= limit) begin
        pos_nxt   = '0;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc[CW-1:0];
        pos_nxt   = (pos_r == PW'(SCHED_LEN - 1)) ? '0 : pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      count_r     <= '0;
      chunk_len_r <= btss_pkg::CHUNK_RESET;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      pass_r      <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      if (cfg_if.valid) begin
        chunk_len_r <= cfg_if.chunk_length;
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_i.x_start) begin
        i_r    <= PW'(KEY_LEN);
        pass_r <= 1'b0;
      end else if (cmd_i.x_calc) begin
        if (stat_o.x_end) begin
          i_r    <= PW'(KEY_LEN);
          pass_r <= ~pass_r;
        end else begin
          i_r <= i_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.key_wr1) begin
      kidx_r <= PW'(in_if.key_index);
      key_r  <= in_if.key_byte[BW-1:0];
    end
    if (cmd_i.data_acc) begin
      data_r <= in_if.data_byte;
    end
    if (cmd_i.out_load) begin
      out_byte_r <= data_r ^ (btss_pkg::BYTE_W'(1) << rdata_r);
    end
    if (cmd_i.x_geta) begin
      a_r <= rdata_r;
    end else if (cmd_i.x_calc) begin
      a_r <= eq ? b : new_b;
    end
  end

  `BTSS_ASSERT(a_out_hold, (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_byte_r)))
  `BTSS_ASSERT(a_key_restarts_pos, cmd_i.key_wr1 |=> (pos_r == '0 && count_r == '0))
  `BTSS_ASSERT_MSG(a_pos_in_range, 32'(pos_r) < 32'(SCHED_LEN), "schedule position out of range")

endmodule

>>> rtl/core/btss_controller.sv
// Scrambler controller: request acceptance, key load sequencing and the
// two-pass schedule expansion sequencer. Depends on btss_pkg.
`include "bit_toggle_stream_scrambler_assert.svh"

module btss_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  btss_pkg::btss_stat_t stat_i,
  output btss_pkg::btss_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_XOR    = 7'b0000010,
    S_KEY2   = 7'b0000100,
    S_X_RDA  = 7'b0001000,
    S_X_GETA = 7'b0010000,
    S_X_RDB  = 7'b0100000,
    S_X_CALC = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take_req;
  logic   key_busy;

  assign key_busy = (state_r != S_IDLE) && (state_r != S_XOR);

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    take_req  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.in_ready = rst_n;
        take_req       = stat_i.in_valid && rst_n;
      end
      S_XOR: begin
        cmd_o.in_ready = stat_i.out_free;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
          take_req       = stat_i.in_valid;
        end
      end
      S_KEY2: begin
        cmd_o.key_wr2 = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.x_start = 1'b1;
          state_nxt     = S_X_RDA;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_X_RDA: begin
        cmd_o.x_rda = 1'b1;
        state_nxt   = S_X_GETA;
      end
      S_X_GETA: begin
        cmd_o.x_geta = 1'b1;
        state_nxt    = S_X_CALC;
      end
      S_X_RDB: begin
        cmd_o.x_rdb = 1'b1;
        state_nxt   = S_X_CALC;
      end
      S_X_CALC: begin
        cmd_o.x_calc = 1'b1;
        if (!stat_i.x_end) begin
          state_nxt = S_X_RDB;
        end else if (!stat_i.pass_last) begin
          state_nxt = S_X_RDA;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (take_req) begin
      if (stat_i.in_cmd == btss_pkg::CMD_DATA) begin
        cmd_o.data_acc = 1'b1;
        state_nxt      = S_XOR;
      end else if (stat_i.idx_ok) begin
        cmd_o.key_wr1 = 1'b1;
        state_nxt     = S_KEY2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BTSS_ASSERT(a_key2_after_wr1, (state_r == S_KEY2) |-> $past(cmd_o.key_wr1))
  `BTSS_ASSERT(a_calc_after_read, (state_r == S_X_CALC) |-> $past(cmd_o.x_geta || cmd_o.x_rdb))
  `BTSS_ASSERT_MSG(a_no_req_in_expand, key_busy |-> !cmd_o.in_ready, "request taken during key load")

endmodule

>>> rtl/core/bit_toggle_stream_scrambler.sv
// Bit toggle stream scrambler, top level. Data byte: the byte and its schedule bit
// are registered, then the result register is loaded once free; one data byte
// per cycle sustained while the output is not stalled. Key byte load: two writes to
// the schedule memory. Last key byte: also runs the two expansion passes, each entry
// step a read, then a calculate-and-write, on the memory port. Sync active-low
// reset clears position, chunk count and control; chunk_length resets to 30000.
module bit_toggle_stream_scrambler #(
  parameter int KEY_LEN = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  btss_in_if.sink      in_if,
  btss_out_if.source   out_if,
  btss_cfg_if.sink     cfg_if
);

  btss_pkg::btss_cmd_t  cmd;
  btss_pkg::btss_stat_t stat;

  btss_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  btss_datapath #(
    .KEY_LEN (KEY_LEN)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for bit_toggle_stream_scrambler: key loads, schedule
// expansion, chunk restarts and data toggling, checked against an in-bench predictor.
// Depends on btss_pkg and the btss_*_if interfaces from the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_IDX_W    = btss_pkg::KEY_IDX_W;
  localparam int BYTE_W       = btss_pkg::BYTE_W;
  localparam int BIT_W        = btss_pkg::BIT_W;
  localparam int CHUNK_W      = btss_pkg::CHUNK_W;

  localparam int KEY_LEN      = 40;
  localparam int SCHED_LEN    = 2 * KEY_LEN;
  localparam int SETTLE       = 2 * (2 * SCHED_LEN) + 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLDOFF_LEN  = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;

  typedef struct packed {
    logic                 cmd;
    logic [KEY_IDX_W-1:0] key_index;
    logic [BYTE_W-1:0]    key_byte;
    logic [BYTE_W-1:0]    data_byte;
  } scr_req_t;

  logic clk = 1'b0;
  logic rst_n;

  btss_in_if  in_ch ();
  btss_out_if out_ch ();
  btss_cfg_if cfg_ch ();

  bit_toggle_stream_scrambler #(.KEY_LEN(KEY_LEN)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [BIT_W-1:0]   sched_bits [SCHED_LEN];
  int unsigned        sched_pos;
  int unsigned        chunk_cnt;
  logic [CHUNK_W-1:0] chunk_len;
  logic [BYTE_W-1:0]  expected_bytes [$];

  int  err_count;
  bit  quiet;
  int  holdoff;
  int  stall_cycles;

  task automatic report_failure(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic void expand_schedule();
    int a;
    int b;
    for (int p = 0; p < 2; p++) begin
      for (int i = KEY_LEN; i < SCHED_LEN - 1; i++) begin
        a = sched_bits[i];
        b = sched_bits[i+1];
        if (a == b) begin
          sched_bits[i] = BIT_W'((a + b + 2 * i) & 7);
        end else if (b + 2 * i > 7) begin
          sched_bits[i+1] = BIT_W'((b + 3 * i) & 7);
        end else begin
          sched_bits[i+1] = BIT_W'((b + 2 * i) & 7);
        end
      end
    end
  endfunction

  task automatic predict_toggle(input scr_req_t r);
    int unsigned pos;
    int unsigned lim;
    int unsigned nxt;
    logic [BIT_W-1:0] bitn;
    if (r.cmd == btss_pkg::CMD_KEY) begin
      if (r.key_index < KEY_LEN) begin
        sched_bits[r.key_index]           = r.key_byte[BIT_W-1:0];
        sched_bits[r.key_index + KEY_LEN] = r.key_byte[BIT_W-1:0];
        if (r.key_index == KEY_LEN - 1) begin
          expand_schedule();
        end
        sched_pos = 0;
        chunk_cnt = 0;
      end
    end else begin
      pos  = (sched_pos < SCHED_LEN) ? sched_pos : 0;
      bitn = sched_bits[pos];
      expected_bytes.push_back(r.data_byte ^ (BYTE_W'(1) << bitn));
      lim = (chunk_len == 0) ? 65536 : chunk_len;
      nxt = chunk_cnt + 1;
      if (nxt >= lim) begin
        chunk_cnt = 0;
        sched_pos = 0;
      end else begin
        chunk_cnt = nxt;
        sched_pos = (pos + 1 >= SCHED_LEN) ? 0 : pos + 1;
      end
    end
  endtask

  function automatic scr_req_t key_req(input int idx, input logic [BYTE_W-1:0] v);
    scr_req_t r;
    r.cmd       = btss_pkg::CMD_KEY;
    r.key_index = KEY_IDX_W'(idx);
    r.key_byte  = v;
    r.data_byte = BYTE_W'($urandom);
    return r;
  endfunction

  function automatic scr_req_t data_req(input logic [BYTE_W-1:0] d);
    scr_req_t r;
    r.cmd       = btss_pkg::CMD_DATA;
    r.key_index = KEY_IDX_W'($urandom);
    r.key_byte  = BYTE_W'($urandom);
    r.data_byte = d;
    return r;
  endfunction

  task automatic send_request(input scr_req_t r);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.cmd       = r.cmd;
    in_ch.key_index = r.key_index;
    in_ch.key_byte  = r.key_byte;
    in_ch.data_byte = r.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    predict_toggle(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_chunk_length(input logic [CHUNK_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_ch.valid        = 1'b1;
    cfg_ch.chunk_length = v;
    do @(posedge clk); while (!cfg_ch.ready);
    chunk_len = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic load_full_key(input bit same_value, input logic [BYTE_W-1:0] v);
    for (int k = 0; k < KEY_LEN; k++) begin
      send_request(key_req(k, same_value ? v : BYTE_W'($urandom)));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    logic [BYTE_W-1:0] exp_byte;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_failure($sformatf("unexpected result %02h", out_ch.out_byte));
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (out_ch.out_byte !== exp_byte) begin
          report_failure($sformatf("out_byte mismatch: expected %02h actual %02h",
                                   exp_byte, out_ch.out_byte));
        end
      end
    end
  end

  // result ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (holdoff > 0) begin
      out_ch.ready = 1'b0;
      holdoff--;
    end else begin
      out_ch.ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_full_key();
    send_request(key_req(KEY_LEN, 8'h00));
    send_request(key_req(63, 8'hFF));
    send_request(key_req(0, 8'h00));
    send_request(key_req(1, 8'hFF));
    for (int k = 2; k < KEY_LEN; k++) begin
      send_request(key_req(k, BYTE_W'($urandom)));
    end
    for (int n = 0; n < 8; n++) begin
      send_request(data_req(BYTE_W'($urandom)));
    end
    drain_results();
    // all key bytes equal: every step of the first expansion pass hits the equal-neighbor rule
    load_full_key(1'b1, 8'h05);
    for (int n = 0; n < 4; n++) begin
      send_request(data_req(BYTE_W'($urandom)));
    end
  endtask

  task automatic test_data_extremes();
    send_request(data_req(8'h00));
    send_request(data_req(8'hFF));
    send_request(data_req(8'h80));
    send_request(data_req(8'h01));
    send_request(data_req(8'h55));
    send_request(data_req(8'hAA));
  endtask

  task automatic test_ignored_index();
    send_request(data_req(8'h3C));
    send_request(key_req(KEY_LEN, 8'hFF));
    send_request(key_req(63, 8'h07));
    send_request(data_req(8'hC3));
    send_request(data_req(8'h0F));
  endtask

  task automatic test_partial_reload();
    send_request(key_req(5, 8'hFE));
    send_request(data_req(8'h00));
    send_request(data_req(8'hFF));
    send_request(key_req(KEY_LEN - 1, 8'h03));
    send_request(data_req(8'h00));
    send_request(data_req(8'hF0));
  endtask

  task automatic test_chunk_settings();
    write_chunk_length(16'd1);
    repeat (3) send_request(data_req(BYTE_W'($urandom)));
    write_chunk_length(16'd0);
    repeat (3) send_request(data_req(BYTE_W'($urandom)));
    write_chunk_length(16'hFFFF);
    repeat (3) send_request(data_req(BYTE_W'($urandom)));
    write_chunk_length(btss_pkg::CHUNK_RESET);
    repeat (20) send_request(data_req(BYTE_W'($urandom)));
    // new length below the running count: next byte closes the chunk
    write_chunk_length(16'd5);
    repeat (3) send_request(data_req(BYTE_W'($urandom)));
  endtask

  task automatic test_backpressure();
    drain_results();
    holdoff = HOLDOFF_LEN;
    repeat (40) send_request(data_req(BYTE_W'($urandom)));
  endtask

  task automatic test_random();
    int unsigned picks [8] = '{1, 2, 79, 80, 81, 0, 65535, 7};
    int          done;
    int          roll;
    int          idx;
    logic [CHUNK_W-1:0] len;
    for (int ph = 0; ph < PHASES; ph++) begin
      len = ($urandom_range(0, 2) == 0) ? CHUNK_W'($urandom_range(1, 200)) : CHUNK_W'(picks[ph]);
      write_chunk_length(len);
      quiet = (ph == 2);
      done  = 0;
      while (done < PHASE_ITEMS) begin
        roll = $urandom_range(0, 999);
        if (roll < 6) begin
          load_full_key(1'b0, 8'h00);
          done += KEY_LEN;
        end else if (roll < 80) begin
          if ($urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, 63);
          end else if ($urandom_range(0, 9) == 0) begin
            idx = KEY_LEN - 1;
          end else begin
            idx = $urandom_range(0, KEY_LEN - 1);
          end
          send_request(key_req(idx, BYTE_W'($urandom)));
          if (idx < KEY_LEN) begin
            done++;
          end
        end else begin
          send_request(data_req(BYTE_W'($urandom)));
          done++;
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    err_count           = 0;
    quiet               = 1'b0;
    holdoff             = 0;
    stall_cycles        = 0;
    sched_pos           = 0;
    chunk_cnt           = 0;
    chunk_len           = btss_pkg::CHUNK_RESET;
    for (int k = 0; k < SCHED_LEN; k++) begin
      sched_bits[k] = '0;
    end
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = btss_pkg::CMD_DATA;
    in_ch.key_index     = '0;
    in_ch.key_byte      = '0;
    in_ch.data_byte     = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.chunk_length = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_full_key();
    test_data_extremes();
    test_ignored_index();
    test_partial_reload();
    test_chunk_settings();
    test_backpressure();
    test_random();
    drain_results();

    if (expected_bytes.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_bytes.size()));
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/btss_pkg.sv
rtl/core/btss_if.sv
rtl/core/btss_datapath.sv
rtl/core/btss_controller.sv
rtl/core/bit_toggle_stream_scrambler.sv
tb/tb_top.sv
